// ===== rtl/srdc_pkg.sv =====
// ----------------------------------------------------------------------------
// srdc_pkg
// Shared constants, types and helpers of the signed radix digit converter.
// ----------------------------------------------------------------------------
package srdc_pkg;

    localparam int VALUE_W     = 32;
    localparam int VALUE_BITS  = 32;
    localparam int OPCODE_W    = 2;
    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 7;
    localparam int DIG_W       = RADIX_W;
    localparam int BIT_W       = $clog2(DIG_W);
    localparam int WIDE_BITS   = VALUE_BITS + RADIX_W - 1;
    localparam int DSR_W       = WIDE_BITS + DIG_W - 1;
    localparam int POW_DEPTH   = VALUE_BITS;
    localparam int POW_ADDR_W  = $clog2(POW_DEPTH);
    localparam int CNT_W       = $clog2(POW_DEPTH + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [DIG_W-1:0]   DEC_MAX     = 6'd9;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'd48;
    localparam logic [CHAR_W-1:0]  CHAR_ONE    = 7'd49;
    localparam logic [CHAR_W-1:0]  ALPHA_OFS   = 7'd55;
    localparam logic [CHAR_W-1:0]  CHAR_MAX    = 7'd90;
    localparam logic [CHAR_W-1:0]  CHAR_NONE   = 7'd0;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PLAIN      = 2'd0,
        OP_DIMINISHED = 2'd1,
        OP_RADIX      = 2'd2,
        OP_SIGN_MAG   = 2'd3
    } opcode_t;

    typedef struct packed {
        logic                  err;
        logic                  cmpl;
        logic                  dim;
        logic                  sign;
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
    } cmd_t;

    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIG_W-1:0] d);
        logic [CHAR_W-1:0] dc;
        dc = CHAR_W'(d);
        return (d > DEC_MAX) ? (dc + ALPHA_OFS) : (dc + CHAR_ZERO);
    endfunction

endpackage

// ===== rtl/srdc_ram.sv =====
// ----------------------------------------------------------------------------
// srdc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module srdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/srdc_front.sv =====
// ----------------------------------------------------------------------------
// srdc_front
// Accepts input items, classifies sign and mode, queues commands.
// ----------------------------------------------------------------------------
module srdc_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [srdc_pkg::VALUE_W-1:0]    s_tdata,
    input  logic [srdc_pkg::OPCODE_W-1:0]   s_tuser,
    output logic                            cmd_valid,
    input  logic                            cmd_ready,
    output srdc_pkg::cmd_t                  cmd
);
    import srdc_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    logic [VALUE_BITS-1:0] raw;
    opcode_t               op;
    cmd_t                  cls;
    logic                  push;
    logic                  pop;

    // classify
    always_comb begin
        raw      = s_tdata[VALUE_BITS-1:0];
        op       = opcode_t'(s_tuser);
        cls.neg  = raw[VALUE_BITS-1];
        cls.mag  = cls.neg ? (~raw + VALUE_BITS'(1)) : raw;
        cls.sign = (op == OP_SIGN_MAG);
        cls.err  = cls.neg && (op == OP_PLAIN);
        cls.cmpl = cls.neg && ((op == OP_DIMINISHED) || (op == OP_RADIX));
        cls.dim  = (op == OP_DIMINISHED);
    end

    assign s_tready  = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = mem_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? (wr_ptr_reg + QPTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = pop ? (rd_ptr_reg + QPTR_W'(1)) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== rtl/srdc_back.sv =====
// ----------------------------------------------------------------------------
// srdc_back
// Emits the error item or sign digit, builds the power table, forms the
// complement and divides out the digits most significant first into the output register.
// ----------------------------------------------------------------------------
module srdc_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [srdc_pkg::RADIX_W-1:0]   radix,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  srdc_pkg::cmd_t                 cmd,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [srdc_pkg::CHAR_W-1:0]    out_char,
    output logic                           out_last,
    output logic                           out_err
);
    import srdc_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_ERR  = 8'b0000_0010,
        ST_SIGN = 8'b0000_0100,
        ST_POW  = 8'b0000_1000,
        ST_COMP = 8'b0001_0000,
        ST_RD   = 8'b0010_0000,
        ST_LOAD = 8'b0100_0000,
        ST_DIV  = 8'b1000_0000
    } state_t;

    localparam state_t ST_EMIT_UNUSED = ST_IDLE;

    typedef enum logic [1:0] {
        PH_DIV  = 2'b01,
        PH_EMIT = 2'b10
    } phase_t;

    state_t               state_reg, state_next;
    phase_t               phase_reg, phase_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [WIDE_BITS-1:0] x_reg, x_next;
    logic [WIDE_BITS-1:0] p_reg, p_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [DSR_W-1:0]     dsr_reg, dsr_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    logic [DIG_W-1:0]     digit_reg, digit_next;
    logic                 started_reg, started_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]    out_char_reg, out_char_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_err_reg, out_err_next;

    logic [WIDE_BITS+RADIX_W-1:0] prod;
    logic [WIDE_BITS-1:0]         mag_ext;
    logic [CNT_W-1:0]             k_dec;
    logic                         out_free;
    logic                         load_out;
    logic                         emit_req;
    logic                         ram_we;
    logic                         ram_re;
    logic [WIDE_BITS-1:0]         ram_rd_data;

    assign prod     = p_reg * radix;
    assign mag_ext  = WIDE_BITS'(cmd_reg.mag);
    assign k_dec    = k_reg - CNT_W'(1);
    assign out_free = !out_valid_reg || m_tready;
    assign emit_req = (digit_reg != '0) || started_reg || (k_reg == CNT_W'(1));

    srdc_ram #(
        .WIDTH (WIDE_BITS),
        .DEPTH (POW_DEPTH)
    ) u_pow_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (k_reg[POW_ADDR_W-1:0]),
        .wr_data (p_reg),
        .rd_en   (ram_re),
        .rd_addr (k_dec[POW_ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        cmd_next      = cmd_reg;
        x_next        = x_reg;
        p_next        = p_reg;
        k_next        = k_reg;
        dsr_next      = dsr_reg;
        bit_next      = bit_reg;
        digit_next    = digit_reg;
        started_next  = started_reg;
        out_char_next = out_char_reg;
        out_last_next = out_last_reg;
        out_err_next  = out_err_reg;
        load_out      = 1'b0;
        cmd_ready     = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    cmd_next     = cmd;
                    x_next       = WIDE_BITS'(cmd.mag);
                    p_next       = WIDE_BITS'(1);
                    k_next       = '0;
                    started_next = 1'b0;
                    if (cmd.err) begin
                        state_next = ST_ERR;
                    end else if (cmd.sign) begin
                        state_next = ST_SIGN;
                    end else begin
                        state_next = ST_POW;
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    load_out      = 1'b1;
                    out_char_next = CHAR_NONE;
                    out_last_next = 1'b1;
                    out_err_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    load_out      = 1'b1;
                    out_char_next = cmd_reg.neg ? CHAR_ONE : CHAR_ZERO;
                    out_last_next = 1'b0;
                    out_err_next  = 1'b0;
                    state_next    = ST_POW;
                end
            end
            ST_POW: begin
                // powers radix^0 .. radix^(L-1) go to the table, p ends at radix^L
                if ((p_reg > x_reg) && (k_reg != '0)) begin
                    state_next = cmd_reg.cmpl ? ST_COMP : ST_RD;
                end else begin
                    ram_we = 1'b1;
                    p_next = prod[WIDE_BITS-1:0];
                    k_next = k_reg + CNT_W'(1);
                end
            end
            ST_COMP: begin
                x_next     = p_reg - mag_ext - WIDE_BITS'(cmd_reg.dim);
                state_next = ST_RD;
            end
            ST_RD: begin
                ram_re     = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                dsr_next   = {ram_rd_data, {(DIG_W-1){1'b0}}};
                bit_next   = BIT_W'(DIG_W - 1);
                digit_next = '0;
                phase_next = PH_DIV;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                case (phase_reg)
                    PH_DIV: begin
                        if (DSR_W'(x_reg) >= dsr_reg) begin
                            x_next              = x_reg - dsr_reg[WIDE_BITS-1:0];
                            digit_next[bit_reg] = 1'b1;
                        end
                        dsr_next = dsr_reg >> 1;
                        if (bit_reg == '0) begin
                            phase_next = PH_EMIT;
                        end else begin
                            bit_next = bit_reg - BIT_W'(1);
                        end
                    end
                    PH_EMIT: begin
                        // leading zero digits are dropped, but the last digit is always emitted
                        if (!emit_req || out_free) begin
                            if (emit_req) begin
                                load_out      = 1'b1;
                                out_char_next = digit_ascii(digit_reg);
                                out_last_next = (k_reg == CNT_W'(1));
                                out_err_next  = 1'b0;
                                started_next  = 1'b1;
                            end
                            k_next     = k_dec;
                            state_next = (k_reg == CNT_W'(1)) ? ST_IDLE : ST_RD;
                        end
                    end
                    default: begin
                        phase_next = PH_DIV;
                    end
                endcase
            end
            default: begin
                state_next = ST_EMIT_UNUSED;
            end
        endcase

        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_DIV;
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            started_reg   <= started_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        x_reg        <= x_next;
        p_reg        <= p_next;
        k_reg        <= k_next;
        dsr_reg      <= dsr_next;
        bit_reg      <= bit_next;
        digit_reg    <= digit_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign out_char = out_char_reg;
    assign out_last = out_last_reg;
    assign out_err  = out_err_reg;

endmodule

// ===== rtl/signed_radix_digit_converter.sv =====
// ----------------------------------------------------------------------------
// signed_radix_digit_converter
// Converts a signed integer to ASCII digits in a configurable base (2 to 36),
// most significant digit first, with plain, diminished radix complement,
// radix complement and sign digit plus magnitude modes.
// ----------------------------------------------------------------------------
// An item whose magnitude has L digits is taken as a command, emits its sign
// digit in sign digit plus magnitude mode, fills the power table with
// radix^0 to radix^(L-1), forms the complement if it is a negative value in
// a complement mode, then per digit takes one table read, one load, six
// restoring divide steps against that power and one output step. A
// plain-mode negative value goes from the idle state to the error state,
// which loads its error item. The digit engine works on one item at a time;
// a two-entry command queue in front of it takes new items meanwhile, and the
// output register holds one finished digit while the next one is computed.
module signed_radix_digit_converter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [srdc_pkg::RADIX_W-1:0]  cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // value
    input  logic [1:0]                    s_tuser,   // opcode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // digit_char, zero pad
    output logic                          m_tlast,
    output logic [0:0]                    m_tuser    // error
);
    import srdc_pkg::*;

    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic [RADIX_W-1:0] radix_eff;
    logic               cmd_valid;
    logic               cmd_ready;
    cmd_t               cmd;
    logic [CHAR_W-1:0]  out_char;
    logic               out_last;
    logic               out_err;

    assign radix_next = cfg_wr_en ? cfg_wr_data : radix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else begin
            radix_reg <= radix_next;
        end
    end

    always_comb begin
        if (radix_reg < RADIX_MIN) begin
            radix_eff = RADIX_MIN;
        end else if (radix_reg > RADIX_MAX) begin
            radix_eff = RADIX_MAX;
        end else begin
            radix_eff = radix_reg;
        end
    end

    srdc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    srdc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .radix     (radix_eff),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_char  (out_char),
        .out_last  (out_last),
        .out_err   (out_err)
    );

    assign m_tdata = {1'b0, out_char};
    assign m_tlast = out_last;
    assign m_tuser = out_err;

    // error item always closes its conversion
    a_err_last : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_err) |-> out_last)
        else $error("error item without last");

    a_err_char : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_err) |-> (out_char == CHAR_NONE))
        else $error("error item with nonzero char");

    a_digit_char : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !out_err) |-> ((out_char >= CHAR_ZERO) && (out_char <= CHAR_MAX)))
        else $error("digit char out of range");

    a_cmd_wait : assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_valid && !cmd_ready) |=> cmd_valid)
        else $error("queued command lost");

endmodule

// ===== bench/tb_signed_radix_digit_converter.sv =====
// ----------------------------------------------------------------------------
// tb_signed_radix_digit_converter
// Self-checking bench for the signed radix digit converter. Signed values
// with random modes are streamed in bursts under a set of radix settings
// (including out-of-range ones that clamp), every emitted digit item is
// compared against a behavioral predictor, and the receiver stalls randomly.
// ----------------------------------------------------------------------------
module tb_signed_radix_digit_converter;
    timeunit 1ns;
    timeprecision 1ps;

    import srdc_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int DRAIN_CYCLES   = 400;
    localparam int ITEMS_PER_SET  = 34;
    localparam int NUM_SETS       = 9;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        opcode_t            op;
    } conv_item_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
        logic       err;
    } digit_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [RADIX_W-1:0]   cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata     = '0;
    logic [1:0]           s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [7:0]           m_tdata;
    logic                 m_tlast;
    logic [0:0]           m_tuser;

    conv_item_t           pending_items[$];
    digit_t               digit_q[$];
    logic [RADIX_W-1:0]   cur_radix = RADIX_RESET;
    int                   mismatch_count = 0;
    int                   cycle_count = 0;

    int                   burst_left = 1;
    int                   gap_left = 0;
    logic                 next_valid;
    conv_item_t           next_item;

    int                   ready_mode = 0;
    int                   ready_cnt = 0;

    signed_radix_digit_converter u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void push_number(longint unsigned x, longint unsigned n);
        logic [7:0]      digs[$];
        longint unsigned d;
        do begin
            d = x % n;
            digs.push_front((d > 9) ? 8'(d) + 8'(ALPHA_OFS) : 8'(d) + 8'(CHAR_ZERO));
            x = x / n;
        end while (x != 0);
        foreach (digs[i])
            digit_q.push_back('{digs[i], (i == digs.size() - 1), 1'b0});
    endfunction

    function automatic void predict_digits(input logic [VALUE_W-1:0] value, input opcode_t op);
        longint unsigned full, raw, mag, n, p;
        logic            neg;
        int              len;
        full = 64'd1 << VALUE_BITS;
        raw  = longint'(value) & (full - 1);
        n    = (cur_radix < RADIX_MIN) ? RADIX_MIN :
               (cur_radix > RADIX_MAX) ? RADIX_MAX : cur_radix;
        neg  = ((raw >> (VALUE_BITS - 1)) & 1) != 0;
        mag  = neg ? (full - raw) : raw;
        if (op == OP_SIGN_MAG) begin
            digit_q.push_back('{neg ? 8'(CHAR_ONE) : 8'(CHAR_ZERO), 1'b0, 1'b0});
            push_number(mag, n);
        end else if (!neg) begin
            push_number(mag, n);
        end else if (op == OP_PLAIN) begin
            digit_q.push_back('{8'(CHAR_NONE), 1'b1, 1'b1});
        end else begin
            len = 1;
            p = mag;
            while (p >= n) begin
                p = p / n;
                len++;
            end
            p = 1;
            repeat (len) p = p * n;
            p = p - mag;
            if (op == OP_DIMINISHED)
                p = p - 1;
            push_number(p, n);
        end
    endfunction

    function automatic void note_failure(string msg);
        if (mismatch_count < 10)
            $display("%0t: %s", $realtime, msg);
        mismatch_count++;
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return 0;
        else if (sel < 9)
            return $urandom_range(1, 5);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value(input logic [RADIX_W-1:0] r);
        longint unsigned n, p;
        int              k;
        logic [VALUE_W-1:0] v;
        n = (r < RADIX_MIN) ? RADIX_MIN : (r > RADIX_MAX) ? RADIX_MAX : r;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2: v = VALUE_W'(int'($urandom_range(0, 100)) - 50);
            3: begin
                p = 1;
                k = $urandom_range(0, 31);
                repeat (k) if (p * n < 64'h8000_0000) p = p * n;
                v = VALUE_W'(p + $urandom_range(0, 2) - 1);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            4: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 32'h0000_0000;
                    3: v = 32'hffff_ffff;
                    default: v = 32'h0000_0001;
                endcase
            end
            default: begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    // source side: bursts of items separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            gap_left   <= 0;
            burst_left <= $urandom_range(1, 24);
        end else begin
            if (s_tvalid && s_tready)
                predict_digits(s_tdata, opcode_t'(s_tuser));
            next_valid = s_tvalid;
            if (!s_tvalid || s_tready) begin
                next_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_items.size() != 0) begin
                    next_item = pending_items.pop_front();
                    s_tdata   <= next_item.value;
                    s_tuser   <= next_item.op;
                    next_valid = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= pick_gap();
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // sink side: stall pattern is redrawn whenever its countdown runs out
    always @(posedge aclk) begin
        if (ready_cnt == 0) begin
            ready_mode <= $urandom_range(0, 3);
            ready_cnt  <= $urandom_range(20, 200);
        end else begin
            ready_cnt <= ready_cnt - 1;
        end
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 1) != 0);
            default: m_tready <= (ready_cnt[2:0] == 3'd0);
        endcase
    end

    always @(posedge aclk) begin
        digit_t exp_digit;
        if (aresetn && m_tvalid && m_tready) begin
            if (digit_q.size() == 0) begin
                note_failure($sformatf("unexpected item data=%0d last=%0b err=%0b",
                                       m_tdata, m_tlast, m_tuser[0]));
            end else begin
                exp_digit = digit_q.pop_front();
                if (m_tdata !== exp_digit.char_code || m_tlast !== exp_digit.last ||
                        m_tuser[0] !== exp_digit.err)
                    note_failure($sformatf(
                        "mismatch: expected data=%0d last=%0b err=%0b, got data=%0d last=%0b err=%0b",
                        exp_digit.char_code, exp_digit.last, exp_digit.err,
                        m_tdata, m_tlast, m_tuser[0]));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("signed_radix_digit_converter test failed");
            $finish;
        end
    end

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_tvalid || digit_q.size() != 0);
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] r);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= r;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_radix    = r;
    endtask

    initial begin
        logic [RADIX_W-1:0] set_radix[NUM_SETS];
        logic [VALUE_W-1:0] edge_vals[4];
        opcode_t            op;
        set_radix = '{6'd2, 6'd36, 6'd0, 6'd63, 6'd16, 6'd1, 6'd37, 6'd7, 6'd10};
        set_radix[NUM_SETS-1] = RADIX_W'($urandom_range(2, 36));
        edge_vals = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed items at the reset radix
        for (int o = 0; o < 4; o++) begin
            op = opcode_t'(o);
            foreach (edge_vals[i])
                pending_items.push_back('{edge_vals[i], op});
        end
        pending_items.push_back('{-32'sd9, OP_DIMINISHED});
        pending_items.push_back('{-32'sd10, OP_RADIX});
        pending_items.push_back('{-32'sd1000, OP_RADIX});
        pending_items.push_back('{32'd1, OP_PLAIN});
        pending_items.push_back('{32'd35, OP_SIGN_MAG});
        wait_idle();

        foreach (set_radix[s]) begin
            write_radix(set_radix[s]);
            repeat (ITEMS_PER_SET)
                pending_items.push_back('{rand_value(set_radix[s]),
                                          opcode_t'($urandom_range(0, 3))});
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (digit_q.size() != 0)
            note_failure($sformatf("%0d expected items never arrived", digit_q.size()));

        if (mismatch_count == 0)
            $display("signed_radix_digit_converter test passed");
        else
            $display("signed_radix_digit_converter test failed");
        $finish;
    end

endmodule
